// ===== design/ipdfe_pkg.sv =====
// ipdfe_pkg: shared types and constants for the IR pulse-distance frame encoder.
// Holds the item structs, the register set, the command and phase codes.
// No dependencies.
`default_nettype none

package ipdfe_pkg;

   // Configuration port geometry
   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 32;

   // Register indexes
   localparam logic [CsrIndexWidth-1:0] RegPreambleBits   = 3'd0;
   localparam logic [CsrIndexWidth-1:0] RegPausePeriods   = 3'd1;
   localparam logic [CsrIndexWidth-1:0] RegHeaderMarkLen  = 3'd2;
   localparam logic [CsrIndexWidth-1:0] RegHeaderSpaceLen = 3'd3;
   localparam logic [CsrIndexWidth-1:0] RegMarkLen        = 3'd4;
   localparam logic [CsrIndexWidth-1:0] RegZeroSpaceLen   = 3'd5;
   localparam logic [CsrIndexWidth-1:0] RegOneSpaceLen    = 3'd6;

   // Register reset values
   localparam logic [31:0] PreambleReset    = 32'h00A0_2002;
   localparam logic [15:0] PauseReset       = 16'd187;
   localparam logic [7:0]  HeaderMarkReset  = 8'd128;
   localparam logic [7:0]  HeaderSpaceReset = 8'd51;
   localparam logic [7:0]  MarkReset        = 8'd13;
   localparam logic [7:0]  ZeroSpaceReset   = 8'd13;
   localparam logic [7:0]  OneSpaceReset    = 8'd38;

   // Code word layout
   localparam int unsigned CodeWidth   = 28;
   localparam int unsigned ShortSelBit = 31;
   localparam logic [7:0]  ShortTarget = 8'd24;
   localparam logic [7:0]  LongTarget  = 8'd0;   // 8-bit count wraps: 256 bits

   typedef enum logic [1:0] {
      CMD_TICK   = 2'd0,
      CMD_SEND   = 2'd1,
      CMD_REPEAT = 2'd2,
      CMD_STOP   = 2'd3
   } command_type;

   typedef enum logic [3:0] {
      PH_IDLE       = 4'd0,
      PH_HEAD_MARK  = 4'd1,
      PH_HEAD_SPACE = 4'd2,
      PH_PRE_MARK   = 4'd3,
      PH_PRE_SPACE  = 4'd4,
      PH_CODE_MARK  = 4'd5,
      PH_CODE_SPACE = 4'd6,
      PH_TRAIL      = 4'd7,
      PH_PAUSE      = 4'd8
   } phase_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [31:0] code_word;
   } req_type;

   typedef struct packed {
      logic       carrier_on;
      logic [7:0] period_len;
      logic       busy_res;
      logic       frame_started;
      logic       stopped;
   } rsp_type;

   typedef struct packed {
      logic [31:0] preamble_bits;
      logic [15:0] pause_periods;
      logic [7:0]  header_mark_len;
      logic [7:0]  header_space_len;
      logic [7:0]  mark_len;
      logic [7:0]  zero_space_len;
      logic [7:0]  one_space_len;
   } cfg_type;

endpackage

`default_nettype wire

// ===== design/ipdfe_core.sv =====
// ipdfe_core: frame sequencer state and its combinational next-state logic.
// Gives the result of an item combinationally from the current state.
// Depends on ipdfe_pkg.
`default_nettype none

module ipdfe_core
   import ipdfe_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    accept,
   input  wire req_type req,
   input  wire cfg_type cfg,
   output rsp_type      rsp
);

   phase_type              phase_ff, phase_in;
   logic [31:0]            shift_ff, shift_in;
   logic [CodeWidth-1:0]   code_ff, code_in;
   logic [7:0]             count_ff, count_in;
   logic                   short_ff, short_in;    // 24-bit phases when set
   logic [15:0]            gap_ff, gap_in;
   logic [7:0]             held_ff, held_in;
   logic                   pend_ff, pend_in;

   logic                   started;
   logic                   stop_done;
   logic [7:0]             count_inc;
   logic [15:0]            gap_inc;
   logic [7:0]             target;
   logic [CodeWidth-1:0]   new_code;
   command_type            cmd;

   assign cmd       = command_type'(req.command);
   assign count_inc = count_ff + 8'd1;
   assign gap_inc   = gap_ff + 16'd1;
   assign target    = short_ff ? ShortTarget : LongTarget;
   assign new_code  = req.code_word[CodeWidth-1:0];

   // Next state
   always_comb begin
      phase_in  = phase_ff;
      shift_in  = shift_ff;
      code_in   = code_ff;
      count_in  = count_ff;
      short_in  = short_ff;
      gap_in    = gap_ff;
      held_in   = held_ff;
      pend_in   = pend_ff;
      started   = 1'b0;
      stop_done = 1'b0;
      case (cmd)
         CMD_TICK: begin
            case (phase_ff)
               PH_IDLE: begin
               end
               PH_HEAD_MARK: begin
                  held_in  = cfg.header_mark_len;
                  phase_in = PH_HEAD_SPACE;
               end
               PH_HEAD_SPACE: begin
                  held_in  = cfg.header_space_len;
                  shift_in = cfg.preamble_bits;
                  count_in = 8'd0;
                  phase_in = PH_PRE_MARK;
               end
               PH_PRE_MARK: begin
                  held_in  = cfg.mark_len;
                  phase_in = PH_PRE_SPACE;
               end
               PH_CODE_MARK: begin
                  held_in  = cfg.mark_len;
                  phase_in = PH_CODE_SPACE;
               end
               PH_TRAIL: begin
                  held_in  = cfg.mark_len;
                  phase_in = PH_PAUSE;
               end
               PH_PRE_SPACE: begin
                  held_in  = shift_ff[0] ? cfg.one_space_len : cfg.zero_space_len;
                  shift_in = {1'b0, shift_ff[31:1]};
                  count_in = count_inc;
                  if (count_inc == target) begin
                     count_in = 8'd0;
                     shift_in = {{(32-CodeWidth){1'b0}}, code_ff};
                     phase_in = PH_CODE_MARK;
                  end else begin
                     phase_in = PH_PRE_MARK;
                  end
               end
               PH_CODE_SPACE: begin
                  held_in  = shift_ff[0] ? cfg.one_space_len : cfg.zero_space_len;
                  shift_in = {1'b0, shift_ff[31:1]};
                  count_in = count_inc;
                  phase_in = (count_inc == target) ? PH_TRAIL : PH_CODE_MARK;
               end
               PH_PAUSE: begin
                  held_in = cfg.mark_len;
                  gap_in  = gap_inc;
                  if (gap_inc >= cfg.pause_periods) begin
                     count_in = 8'd0;
                     gap_in   = 16'd0;
                     phase_in = PH_IDLE;
                  end
               end
               default: begin
                  // unreachable codes end the frame like a finished pause
                  held_in  = cfg.mark_len;
                  count_in = 8'd0;
                  gap_in   = 16'd0;
                  phase_in = PH_IDLE;
               end
            endcase
            // deferred stop takes effect as the frame ends
            if (phase_ff != PH_IDLE && phase_in == PH_IDLE && pend_ff) begin
               code_in   = '0;
               pend_in   = 1'b0;
               stop_done = 1'b1;
            end
         end
         CMD_SEND: begin
            short_in = req.code_word[ShortSelBit];
            code_in  = new_code;
            pend_in  = 1'b0;
            if (new_code != '0 && phase_ff == PH_IDLE) begin
               phase_in = PH_HEAD_MARK;
               started  = 1'b1;
            end
         end
         CMD_REPEAT: begin
            if (code_ff != '0 && phase_ff == PH_IDLE) begin
               phase_in = PH_HEAD_MARK;
               started  = 1'b1;
            end
         end
         CMD_STOP: begin
            if (code_ff != '0 && phase_ff != PH_IDLE) begin
               pend_in = 1'b1;
            end else begin
               code_in   = '0;
               pend_in   = 1'b0;
               stop_done = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Result of this item
   always_comb begin
      rsp.carrier_on    = (cmd == CMD_TICK) &&
                          (phase_ff inside {PH_HEAD_MARK, PH_PRE_MARK,
                                            PH_CODE_MARK, PH_TRAIL});
      rsp.period_len    = held_in;
      rsp.busy_res      = (phase_in != PH_IDLE);
      rsp.frame_started = started;
      rsp.stopped       = stop_done;
   end

   // State registers, updated only on an accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         shift_ff <= '0;
         code_ff  <= '0;
         count_ff <= '0;
         short_ff <= 1'b1;
         gap_ff   <= '0;
         held_ff  <= '0;
         pend_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         shift_ff <= shift_in;
         code_ff  <= code_in;
         count_ff <= count_in;
         short_ff <= short_in;
         gap_ff   <= gap_in;
         held_ff  <= held_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/ir_pulse_distance_frame_encoder_unit.sv =====
// ir_pulse_distance_frame_encoder_unit: top level of the IR frame encoder.
// Holds the register set and a two-entry result buffer around ipdfe_core.
// Depends on ipdfe_pkg and ipdfe_core.
`default_nettype none

// Each item (tick, send, repeat or stop) gives exactly one result, which is
// registered in the output register, or in the skid register when that is
// full. A new item can be taken every cycle while req_stall is low. Results
// pass through a two-entry buffer (output register plus skid register), so
// req_stall rises only once both entries are full; it is a register output
// and does not depend on rsp_stall in the same cycle. Registers are written
// through the csr_ port and should only be changed while no frame runs.
module ir_pulse_distance_frame_encoder_unit
   import ipdfe_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire req_type                  req_payload,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output rsp_type                       rsp_payload,
   input  wire logic                     csr_write_enable,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [CsrDataWidth-1:0]  csr_write_data
);

   cfg_type cfg_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   logic    skid_valid_ff;
   rsp_type skid_data_ff;
   rsp_type core_rsp;
   logic    accept;
   logic    take;

   assign req_stall   = skid_valid_ff;
   assign accept      = req_valid && !skid_valid_ff;
   assign take        = rsp_valid_ff && !rsp_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   // Register set
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.preamble_bits    <= PreambleReset;
         cfg_ff.pause_periods    <= PauseReset;
         cfg_ff.header_mark_len  <= HeaderMarkReset;
         cfg_ff.header_space_len <= HeaderSpaceReset;
         cfg_ff.mark_len         <= MarkReset;
         cfg_ff.zero_space_len   <= ZeroSpaceReset;
         cfg_ff.one_space_len    <= OneSpaceReset;
      end else if (csr_write_enable) begin
         case (csr_index)
            RegPreambleBits:   cfg_ff.preamble_bits    <= csr_write_data;
            RegPausePeriods:   cfg_ff.pause_periods    <= csr_write_data[15:0];
            RegHeaderMarkLen:  cfg_ff.header_mark_len  <= csr_write_data[7:0];
            RegHeaderSpaceLen: cfg_ff.header_space_len <= csr_write_data[7:0];
            RegMarkLen:        cfg_ff.mark_len         <= csr_write_data[7:0];
            RegZeroSpaceLen:   cfg_ff.zero_space_len   <= csr_write_data[7:0];
            RegOneSpaceLen:    cfg_ff.one_space_len    <= csr_write_data[7:0];
            default: begin
            end
         endcase
      end
   end

   ipdfe_core u_core (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_payload),
      .cfg    (cfg_ff),
      .rsp    (core_rsp)
   );

   // Result buffer: output register with a skid entry behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (!rsp_valid_ff || take) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (take) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Buffer payload
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            rsp_data_ff <= skid_data_ff;
         end
      end else if (accept) begin
         if (!rsp_valid_ff || take) begin
            rsp_data_ff <= core_rsp;
         end else begin
            skid_data_ff <= core_rsp;
         end
      end
   end

endmodule

`default_nettype wire

// ===== design/ipdfe_checker.sv =====
// ipdfe_checker: port-level assertions for ir_pulse_distance_frame_encoder_unit.
// Bound to the top level below. Depends on ipdfe_pkg.
`default_nettype none

module ipdfe_checker
   import ipdfe_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_stall,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_payload
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // input is only held off while a result is waiting
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result waiting");

   // a started frame is in progress
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.frame_started |-> rsp_payload.busy_res)
      else $error("frame started but not busy");

   // the carrier only runs inside a frame
   a_carrier_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.carrier_on |-> rsp_payload.busy_res)
      else $error("carrier on outside a frame");

   // one item cannot both start a frame and complete a stop
   a_start_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_payload.frame_started && rsp_payload.stopped))
      else $error("start and stop in one item");

endmodule

bind ir_pulse_distance_frame_encoder_unit ipdfe_checker u_ipdfe_checker (.*);

`default_nettype wire
